// ===== src/wac_pkg.sv =====
package wac_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WINDOW_MAX = 64;
  localparam int ADDR_W     = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int LEN_W      = 7;
  localparam int GAIN_W     = 16;
  localparam int SUM_W      = SAMPLE_W + ADDR_W;
  localparam int DIV_W      = SUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int MUL_W      = GAIN_W + 2;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = PROD_W + 16;
  localparam int CA_W       = 2 * GAIN_W;
  localparam int GCA_W      = 3 * GAIN_W;

  localparam logic signed [SAMPLE_W-1:0] MIN_START = SAMPLE_W'(5000);
  localparam logic signed [SAMPLE_W-1:0] MAX_START = SAMPLE_W'(-5000);

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-(2 ** (SAMPLE_W - 1)));

  typedef enum logic [1:0] {
    MODE_CLIP = 2'd0,
    MODE_FOLD = 2'd1,
    MODE_SAW  = 2'd2,
    MODE_PASS = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_MODE     = 2'd0,
    CFG_CUTOFF   = 2'd1,
    CFG_OUT_GAIN = 2'd2,
    CFG_WIN_LEN  = 2'd3
  } cfg_idx_e;

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_DIV_AVG   = 12'b0000_0000_0010,
    ST_DIV_SLOPE = 12'b0000_0000_0100,
    ST_CA        = 12'b0000_0000_1000,
    ST_GCA_LO    = 12'b0000_0001_0000,
    ST_GCA_HI    = 12'b0000_0010_0000,
    ST_FETCH     = 12'b0000_0100_0000,
    ST_READ      = 12'b0000_1000_0000,
    ST_MUL       = 12'b0001_0000_0000,
    ST_SCL_LO    = 12'b0010_0000_0000,
    ST_SCL_HI    = 12'b0100_0000_0000,
    ST_PUT       = 12'b1000_0000_0000
  } state_e;

  // arithmetic shift right by 8, rounding toward zero
  function automatic logic signed [ACC_W-1:0] shr8_tz(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] b;
    b = v[ACC_W-1] ? v + ACC_W'(255) : v;
    return b >>> 8;
  endfunction

  // arithmetic shift right by 16, rounding toward zero
  function automatic logic signed [ACC_W-1:0] shr16_tz(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] b;
    b = v[ACC_W-1] ? v + ACC_W'(65535) : v;
    return b >>> 16;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > SAT_MAX) c = SAT_MAX;
    if (v < SAT_MIN) c = SAT_MIN;
    return c[SAMPLE_W-1:0];
  endfunction

endpackage

// ===== src/wac_ram.sv =====
module wac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/windowed_adaptive_clipper.sv =====
// Loading: one sample per cycle, for each sample that does not close the window.
// Closing: two 22-bit divisions (average, ramp slope) and gain scaling, then for each result
// fetch, RAM read, multiply (and scale in sawtooth mode) and put, on the shared 18x18 MAC.
// The block takes no sample from the closing beat until the last result is in the output register.
// Reset (async, active low): registers to defaults, window empty, output invalid; the sample
// RAM is not cleared, entries are only read after being written in the current window.
module windowed_adaptive_clipper
  import wac_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [GAIN_W-1:0]          cfg_wdata_i,
  // sample input
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                       end_of_clip_i,
  // result output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                       window_last_o
);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  mode_e                      mode_q, mode_d;
  logic [GAIN_W-1:0]          cut_q, cut_d;
  logic [GAIN_W-1:0]          gain_q, gain_d;
  logic [LEN_W-1:0]           wlen_q, wlen_d;

  state_e                     state_q, state_d;

  // window gather state
  logic [CNT_W-1:0]           fill_q, fill_d;
  logic [CNT_W-1:0]           total_q, total_d;
  logic [SUM_W-1:0]           sum_q, sum_d;
  logic signed [SAMPLE_W-1:0] min_q, min_d;
  logic signed [SAMPLE_W-1:0] max_q, max_d;

  // restoring divider
  logic [DIV_W-1:0]           dquo_q, dquo_d;
  logic [ADDR_W-1:0]          drem_q, drem_d;
  logic [CNT_W-1:0]           dden_q, dden_d;
  logic [DIV_CNT_W-1:0]       dcnt_q, dcnt_d;

  // per-window constants and per-entry datapath
  logic [SAMPLE_W-1:0]        avg_q, avg_d;
  logic [SAMPLE_W-1:0]        slope_q, slope_d;
  logic [CA_W-1:0]            ca_q, ca_d;
  logic [GCA_W-1:0]           gca_q, gca_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [MUL_W-1:0]    hold_q, hold_d;
  logic signed [SAMPLE_W-1:0] x_q, x_d;
  logic signed [MUL_W-1:0]    ramp_q, ramp_d;
  logic [ADDR_W-1:0]          idx_q, idx_d;

  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                       out_last_q;

  // ---------------------------------------------------------------------------
  // Handshake and window close decision
  // ---------------------------------------------------------------------------
  logic                       in_acc;
  logic [CNT_W-1:0]           len_eff;
  logic [SAMPLE_W:0]          in_mag;
  logic [SUM_W-1:0]           sum_new;
  logic signed [SAMPLE_W-1:0] min_new, max_new;
  logic [CNT_W-1:0]           fill_new;
  logic                       win_close, win_pad;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);

  // window length clamped to 1..WINDOW_MAX
  always_comb begin
    if (wlen_q == '0) begin
      len_eff = CNT_W'(1);
    end else if (CNT_W'(wlen_q) > CNT_W'(WINDOW_MAX)) begin
      len_eff = CNT_W'(WINDOW_MAX);
    end else begin
      len_eff = CNT_W'(wlen_q);
    end
  end

  assign in_mag    = sample_in_i[SAMPLE_W-1] ? (SAMPLE_W + 1)'(-$signed({sample_in_i[SAMPLE_W-1],
                                                                          sample_in_i}))
                                             : (SAMPLE_W + 1)'(sample_in_i);
  assign sum_new   = sum_q + SUM_W'(in_mag);
  assign min_new   = (sample_in_i < min_q) ? sample_in_i : min_q;
  assign max_new   = (sample_in_i > max_q) ? sample_in_i : max_q;
  assign fill_new  = fill_q + CNT_W'(1);
  assign win_pad   = (fill_new < len_eff);
  assign win_close = !win_pad || end_of_clip_i;

  // ---------------------------------------------------------------------------
  // Sample RAM: written while gathering, read while emitting
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] ram_rdata;

  wac_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_MAX)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (sample_in_i),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Divider step: one quotient bit per cycle
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]       rem_sh;
  logic                   div_ge;
  logic [ADDR_W-1:0]      rem_nx;
  logic [DIV_W-1:0]       quo_nx;
  logic                   div_done;
  logic signed [SAMPLE_W:0] mm_diff;

  assign rem_sh   = {drem_q, dquo_q[DIV_W-1]};
  assign div_ge   = (rem_sh >= dden_q);
  assign rem_nx   = div_ge ? ADDR_W'(rem_sh - dden_q) : ADDR_W'(rem_sh);
  assign quo_nx   = {dquo_q[DIV_W-2:0], div_ge};
  assign div_done = (dcnt_q == DIV_CNT_W'(DIV_W - 1));
  // never negative: every window holds at least one real sample
  assign mm_diff  = {max_q[SAMPLE_W-1], max_q} - {min_q[SAMPLE_W-1], min_q};

  // ---------------------------------------------------------------------------
  // Shared MAC: acc = base + (a * b) << {0,16}
  // ---------------------------------------------------------------------------
  logic signed [MUL_W-1:0]  mac_a, mac_b;
  logic signed [PROD_W-1:0] mac_p;
  logic signed [ACC_W-1:0]  mac_base, mac_term, mac_sum;
  logic                     mac_sh16;

  always_comb begin
    mac_a    = '0;
    mac_b    = '0;
    mac_base = '0;
    mac_sh16 = 1'b0;
    unique case (state_q)
      ST_CA: begin
        // cutoff * average
        mac_a = $signed({2'b00, cut_q});
        mac_b = $signed({2'b00, avg_q});
      end
      ST_GCA_LO, ST_SCL_LO: begin
        // low half of acc times output gain
        mac_a = $signed({2'b00, gain_q});
        mac_b = $signed({2'b00, acc_q[15:0]});
      end
      ST_GCA_HI, ST_SCL_HI: begin
        // high half, weighted by 2^16, added on
        mac_a    = $signed({2'b00, gain_q});
        mac_b    = hold_q;
        mac_base = acc_q;
        mac_sh16 = 1'b1;
      end
      ST_MUL: begin
        if (mode_q == MODE_SAW) begin
          // x * cutoff + ramp * 256
          mac_a    = $signed({2'b00, cut_q});
          mac_b    = MUL_W'(x_q);
          mac_base = ACC_W'(ramp_q) <<< 8;
        end else begin
          mac_a = $signed({2'b00, gain_q});
          mac_b = MUL_W'(x_q);
        end
      end
      default: begin
        mac_a = '0;
      end
    endcase
  end

  assign mac_p    = mac_a * mac_b;
  assign mac_term = mac_sh16 ? (ACC_W'(mac_p) <<< 16) : ACC_W'(mac_p);
  assign mac_sum  = mac_base + mac_term;

  // ---------------------------------------------------------------------------
  // Result shaping for the current entry
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W:0]          x_mag;
  logic                       below_cut;
  logic signed [MUL_W-1:0]    mag_excess;
  logic signed [ACC_W-1:0]    fold_w, clip_t, knee_t, res_full;
  logic signed [SAMPLE_W-1:0] res;

  assign x_mag      = x_q[SAMPLE_W-1] ? (SAMPLE_W + 1)'(-$signed({x_q[SAMPLE_W-1], x_q}))
                                      : (SAMPLE_W + 1)'(x_q);
  assign below_cut  = (CA_W'({x_mag, 8'h00}) < ca_q);
  assign mag_excess = $signed({1'b0, x_mag}) - $signed({2'b00, avg_q});
  assign fold_w     = $signed(ACC_W'(gca_q)) - (ACC_W'(mag_excess) <<< 16);
  assign clip_t     = $signed(ACC_W'(gca_q[GCA_W-1:16]));
  assign knee_t     = (mode_q == MODE_CLIP) ? clip_t : shr16_tz(fold_w);

  always_comb begin
    case (mode_q) inside
      MODE_CLIP, MODE_FOLD: begin
        if (below_cut) begin
          res_full = shr8_tz(acc_q);
        end else begin
          // zero takes the positive side
          res_full = x_q[SAMPLE_W-1] ? -knee_t : knee_t;
        end
      end
      MODE_SAW: res_full = shr16_tz(acc_q);
      default:  res_full = ACC_W'(x_q);
    endcase
  end

  assign res = sat_sample(res_full);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic put_ok, last_entry;

  assign put_ok     = !out_valid_q || !out_stall_i;
  assign last_entry = ({1'b0, idx_q} + CNT_W'(1) == total_q);

  always_comb begin
    mode_d  = mode_q;
    cut_d   = cut_q;
    gain_d  = gain_q;
    wlen_d  = wlen_q;
    state_d = state_q;
    fill_d  = fill_q;
    total_d = total_q;
    sum_d   = sum_q;
    min_d   = min_q;
    max_d   = max_q;
    dquo_d  = dquo_q;
    drem_d  = drem_q;
    dden_d  = dden_q;
    dcnt_d  = dcnt_q;
    avg_d   = avg_q;
    slope_d = slope_q;
    ca_d    = ca_q;
    gca_d   = gca_q;
    acc_d   = acc_q;
    hold_d  = hold_q;
    x_d     = x_q;
    ramp_d  = ramp_q;
    idx_d   = idx_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:     mode_d = mode_e'(cfg_wdata_i[1:0]);
        CFG_CUTOFF:   cut_d  = cfg_wdata_i;
        CFG_OUT_GAIN: gain_d = cfg_wdata_i;
        CFG_WIN_LEN:  wlen_d = cfg_wdata_i[LEN_W-1:0];
        default:      mode_d = mode_q;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          fill_d = fill_new;
          sum_d  = sum_new;
          min_d  = min_new;
          max_d  = max_new;
          if (win_close) begin
            // padded zeros join the min/max but not the average
            if (win_pad) begin
              if (min_new > 0) min_d = '0;
              if (max_new < 0) max_d = '0;
            end
            total_d = win_pad ? len_eff : fill_new;
            dquo_d  = sum_new;
            drem_d  = '0;
            dden_d  = fill_new;
            dcnt_d  = '0;
            state_d = ST_DIV_AVG;
          end
        end
      end
      ST_DIV_AVG: begin
        dquo_d = quo_nx;
        drem_d = rem_nx;
        dcnt_d = dcnt_q + DIV_CNT_W'(1);
        if (div_done) begin
          avg_d   = quo_nx[SAMPLE_W-1:0];
          dquo_d  = DIV_W'(mm_diff[SAMPLE_W-1:0]);
          drem_d  = '0;
          dden_d  = total_q;
          dcnt_d  = '0;
          state_d = ST_DIV_SLOPE;
        end
      end
      ST_DIV_SLOPE: begin
        dquo_d = quo_nx;
        drem_d = rem_nx;
        dcnt_d = dcnt_q + DIV_CNT_W'(1);
        if (div_done) begin
          slope_d = quo_nx[SAMPLE_W-1:0];
          state_d = ST_CA;
        end
      end
      ST_CA: begin
        acc_d   = mac_sum;
        ramp_d  = MUL_W'(min_q);
        state_d = ST_GCA_LO;
      end
      ST_GCA_LO: begin
        ca_d    = acc_q[CA_W-1:0];
        hold_d  = $signed(acc_q[33:16]);
        acc_d   = mac_sum;
        state_d = ST_GCA_HI;
      end
      ST_GCA_HI: begin
        acc_d   = mac_sum;
        gca_d   = mac_sum[GCA_W-1:0];
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        // RAM read issued at idx_q
        state_d = ST_READ;
      end
      ST_READ: begin
        x_d     = ({1'b0, idx_q} < fill_q) ? $signed(ram_rdata) : '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        acc_d   = mac_sum;
        state_d = (mode_q == MODE_SAW) ? ST_SCL_LO : ST_PUT;
      end
      ST_SCL_LO: begin
        hold_d  = $signed(acc_q[33:16]);
        acc_d   = mac_sum;
        state_d = ST_SCL_HI;
      end
      ST_SCL_HI: begin
        acc_d   = mac_sum;
        state_d = ST_PUT;
      end
      ST_PUT: begin
        if (put_ok) begin
          out_valid_d = 1'b1;
          ramp_d      = ramp_q + MUL_W'(slope_q);
          if (last_entry) begin
            idx_d   = '0;
            fill_d  = '0;
            sum_d   = '0;
            min_d   = MIN_START;
            max_d   = MAX_START;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + ADDR_W'(1);
            state_d = ST_FETCH;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CLIP;
      cut_q       <= GAIN_W'(256);
      gain_q      <= GAIN_W'(256);
      wlen_q      <= LEN_W'(WINDOW_MAX);
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      total_q     <= '0;
      sum_q       <= '0;
      min_q       <= MIN_START;
      max_q       <= MAX_START;
      dcnt_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      cut_q       <= cut_d;
      gain_q      <= gain_d;
      wlen_q      <= wlen_d;
      state_q     <= state_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      sum_q       <= sum_d;
      min_q       <= min_d;
      max_q       <= max_d;
      dcnt_q      <= dcnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    dquo_q  <= dquo_d;
    drem_q  <= drem_d;
    dden_q  <= dden_d;
    avg_q   <= avg_d;
    slope_q <= slope_d;
    ca_q    <= ca_d;
    gca_q   <= gca_d;
    acc_q   <= acc_d;
    hold_q  <= hold_d;
    x_q     <= x_d;
    ramp_q  <= ramp_d;
    if ((state_q == ST_PUT) && put_ok) begin
      out_sample_q <= res;
      out_last_q   <= last_entry;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_sample_q;
  assign window_last_o = out_last_q;

endmodule

// ===== dv/windowed_adaptive_clipper_checker.sv =====
`timescale 1ns / 100ps

module windowed_adaptive_clipper_checker
  import wac_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [GAIN_W-1:0]          cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                       end_of_clip_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic signed [SAMPLE_W-1:0] sample_out_i,
  input  logic                       window_last_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int     MAX_REPORTS = 10;
  localparam longint SAMPLE_HI   = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_LO   = -(longint'(1) <<< (SAMPLE_W - 1));

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       window_last;
  } out_beat_t;

  // shadow registers
  mode_e             mode_q;
  logic [GAIN_W-1:0] cutoff_q;
  logic [GAIN_W-1:0] gain_q;
  logic [LEN_W-1:0]  win_len_q;

  // shadow window
  logic signed [SAMPLE_W-1:0] window_img [WINDOW_MAX];
  int                         fill;
  longint                     mag_sum;
  longint                     run_min;
  longint                     run_max;

  out_beat_t predicted_out [$];

  function automatic logic signed [SAMPLE_W-1:0] distort_entry(input longint x, input int idx,
                                                               input longint avg,
                                                               input longint slope);
    longint c, g, mag, r;
    c   = cutoff_q;
    g   = gain_q;
    mag = (x < 0) ? -x : x;
    case (mode_q) inside
      MODE_CLIP, MODE_FOLD: begin
        if (mag * 256 < c * avg) begin
          r = (g * x) / 256;
        end else begin
          if (mode_q == MODE_FOLD) r = (g * c * avg - (mag - avg) * 65536) / 65536;
          else r = (g * c * avg) / 65536;
          // zero counts as positive
          if (x < 0) r = -r;
        end
      end
      MODE_SAW: r = (g * (x * c + (run_min + slope * idx) * 256)) / 65536;
      default:  r = x;
    endcase
    if (r > SAMPLE_HI) r = SAMPLE_HI;
    else if (r < SAMPLE_LO) r = SAMPLE_LO;
    return r[SAMPLE_W-1:0];
  endfunction

  task automatic open_window();
    fill    = 0;
    mag_sum = 0;
    run_min = MIN_START;
    run_max = MAX_START;
  endtask

  // load one sample; on close, queue the whole burst
  task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] s, input logic eoc);
    longint    x, avg, slope, v;
    int        len, total;
    out_beat_t b;
    x = s;
    if (fill < WINDOW_MAX) begin
      window_img[fill] = s;
      fill++;
      mag_sum += (x < 0) ? -x : x;
      if (x < run_min) run_min = x;
      if (x > run_max) run_max = x;
    end
    len = win_len_q;
    if (len < 1) len = 1;
    if (len > WINDOW_MAX) len = WINDOW_MAX;
    if (fill < len && !eoc) return;

    total = (fill > len) ? fill : len;
    // zero padding joins min/max but not the average
    if (fill < total) begin
      if (run_min > 0) run_min = 0;
      if (run_max < 0) run_max = 0;
    end
    avg   = mag_sum / fill;
    slope = (run_max - run_min) / total;
    for (int i = 0; i < total; i++) begin
      v = (i < fill) ? longint'(window_img[i]) : 0;
      b.sample_out  = distort_entry(v, i, avg, slope);
      b.window_last = (i == total - 1);
      predicted_out.push_back(b);
    end
    open_window();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      mode_q       = MODE_CLIP;
      cutoff_q     = GAIN_W'(256);
      gain_q       = GAIN_W'(256);
      win_len_q    = LEN_W'(64);
      open_window();
      predicted_out.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (predicted_out.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS)
            $display("%0t: unexpected result beat: sample_out %0d window_last %0b",
                     $time, sample_out_i, window_last_i);
        end else begin
          want = predicted_out.pop_front();
          if (want.sample_out !== sample_out_i || want.window_last !== window_last_i) begin
            fail_count_o++;
            if (fail_count_o <= MAX_REPORTS)
              $display("%0t: result mismatch: expected sample_out %0d window_last %0b, got %0d %0b",
                       $time, want.sample_out, want.window_last, sample_out_i, window_last_i);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MODE:     mode_q    = mode_e'(cfg_wdata_i[1:0]);
          CFG_CUTOFF:   cutoff_q  = cfg_wdata_i;
          CFG_OUT_GAIN: gain_q    = cfg_wdata_i;
          CFG_WIN_LEN:  win_len_q = cfg_wdata_i[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) absorb_sample(sample_in_i, end_of_clip_i);
      pending_o = predicted_out.size();
    end
  end

endmodule

// ===== dv/windowed_adaptive_clipper_tb.sv =====
`timescale 1ns / 100ps

module windowed_adaptive_clipper_tb
  import wac_pkg::*;
;

  localparam int TOTAL_ITEMS   = 460;
  // longest quiet stretch: window close math plus gaps and register writes
  localparam int QUIET_LIMIT   = 3000;
  // margin after the last result before touching registers or ending the run
  localparam int SETTLE_CYCLES = 20;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [1:0]                 cfg_idx;
  logic [GAIN_W-1:0]          cfg_wdata;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       end_of_clip;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       window_last;

  int fail_count;
  int pending;
  int sent;
  // when set, that side runs back to back with no idle cycles
  bit tx_steady;
  bit rx_steady;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  windowed_adaptive_clipper u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .sample_in_i   (sample_in),
    .end_of_clip_i (end_of_clip),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .sample_out_o  (sample_out),
    .window_last_o (window_last)
  );

  // watches both channels and the register port, predicts every result beat
  windowed_adaptive_clipper_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .sample_in_i   (sample_in),
    .end_of_clip_i (end_of_clip),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .sample_out_i  (sample_out),
    .window_last_i (window_last),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Everything below drives on the falling edge; the DUT and checker sample on the rising one.

  // Register write: the enable is lowered and held low before the task returns, so it is never lowered and
  // raised in the same step when writes follow each other.
  task automatic write_reg(input cfg_idx_e idx, input logic [GAIN_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // One input beat, preceded by a random idle gap unless tx_steady is set. Valid stays high
  // across back-to-back beats; the payload holds while stalled.
  task automatic drive_sample(input logic signed [SAMPLE_W-1:0] s, input logic eoc);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    sample_in   <= s;
    end_of_clip <= eoc;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  // Sender pauses until every predicted beat has come out, then lets the
  // block settle so a register write cannot land on a half-loaded sample.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Q8.8 gains: zero, full scale, unity, near unity, anything.
  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'(256);
      3:       return GAIN_W'($urandom_range(64, 1024));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // Result side: random stall before each beat, or none in steady stretches.
  initial begin : result_sink
    int hold;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      hold = rx_steady ? 0 : $urandom_range(0, 8);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Watchdog: any stretch without a single beat on either channel ends the run.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("windowed_adaptive_clipper test failed");
    $finish;
  end

  initial begin : stimulus
    int                         phase_len;
    int                         eoc_pct;
    bit                         big;
    logic [LEN_W-1:0]           len;
    logic signed [SAMPLE_W-1:0] s;
    logic                       eoc;

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_MODE;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    sample_in   = '0;
    end_of_clip = 1'b0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    sent        = 0;
    // reset held from the start, then released on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part ----
    // full window of four with the sample extremes, reset gains, clip mode
    write_reg(CFG_WIN_LEN, GAIN_W'(4));
    drive_sample(16'sh7FFF, 1'b0);
    drive_sample(16'sh8000, 1'b0);
    drive_sample(16'sd0, 1'b0);
    drive_sample(16'sd1, 1'b0);
    drain_outputs();

    // fold back, short window closed by end of clip: two zeros of padding
    write_reg(CFG_MODE, GAIN_W'(MODE_FOLD));
    drive_sample(16'sd100, 1'b0);
    drive_sample(16'sh8000, 1'b1);
    drain_outputs();

    // sawtooth at full-scale gains with padding; min/max are the sample extremes
    write_reg(CFG_MODE, GAIN_W'(MODE_SAW));
    write_reg(CFG_CUTOFF, '1);
    write_reg(CFG_OUT_GAIN, '1);
    drive_sample(16'sh8000, 1'b0);
    drive_sample(16'sh7FFF, 1'b1);
    drain_outputs();

    // pass through with a zero window length, which behaves as length one
    write_reg(CFG_MODE, GAIN_W'(MODE_PASS));
    write_reg(CFG_WIN_LEN, GAIN_W'(0));
    drive_sample(16'sh8000, 1'b0);
    drain_outputs();

    // clip with zero cutoff: every sample clips, a zero sample takes the positive sign
    write_reg(CFG_MODE, GAIN_W'(MODE_CLIP));
    write_reg(CFG_CUTOFF, '0);
    write_reg(CFG_OUT_GAIN, GAIN_W'(256));
    write_reg(CFG_WIN_LEN, GAIN_W'(3));
    drive_sample(16'sd0, 1'b0);
    drive_sample(-16'sd7, 1'b1);
    drain_outputs();

    // length dropped below the fill: next sample closes with all six, no padding
    write_reg(CFG_MODE, GAIN_W'(MODE_FOLD));
    write_reg(CFG_CUTOFF, GAIN_W'(384));
    write_reg(CFG_WIN_LEN, GAIN_W'(8));
    drive_sample(16'sd1200, 1'b0);
    drive_sample(-16'sd300, 1'b0);
    drive_sample(16'sd50, 1'b0);
    drive_sample(-16'sd4000, 1'b0);
    drive_sample(16'sd20000, 1'b0);
    drain_outputs();
    write_reg(CFG_WIN_LEN, GAIN_W'(2));
    drive_sample(16'sd77, 1'b0);
    drain_outputs();

    // length beyond the window store saturates; close early by end of clip
    write_reg(CFG_MODE, GAIN_W'(MODE_CLIP));
    write_reg(CFG_CUTOFF, GAIN_W'(512));
    write_reg(CFG_WIN_LEN, GAIN_W'(127));
    drive_sample(-16'sd9000, 1'b0);
    drive_sample(16'sd3000, 1'b1);

    // ---- random part ----
    // Each phase: drain (pressure point), new settings, then a run of samples.
    // A phase may end with a window half full, so settings also change mid-window,
    // including a length dropped below the current fill.
    while (sent < TOTAL_ITEMS) begin
      drain_outputs();
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      write_reg(CFG_MODE, GAIN_W'($urandom_range(0, 3)));
      write_reg(CFG_CUTOFF, pick_gain());
      write_reg(CFG_OUT_GAIN, pick_gain());
      // mostly short windows; now and then the edges of the length range
      big = ($urandom_range(0, 7) == 0);
      if (big) begin
        case ($urandom_range(0, 3))
          0:       len = LEN_W'(0);
          1:       len = LEN_W'(64);
          2:       len = LEN_W'(127);
          default: len = LEN_W'($urandom_range(65, 126));
        endcase
      end else begin
        len = LEN_W'($urandom_range(1, 16));
      end
      write_reg(CFG_WIN_LEN, GAIN_W'(len));
      phase_len = big ? $urandom_range(60, 80) : $urandom_range(8, 40);
      // rare end of clip on long windows so some of them fill completely
      eoc_pct   = big ? $urandom_range(0, 3) : $urandom_range(0, 25);
      repeat (phase_len) begin
        case ($urandom_range(0, 5))
          0:       s = SAMPLE_W'(int'($urandom_range(0, 4)) - 2);
          1:       s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          2:       s = SAMPLE_W'(int'($urandom_range(0, 600)) - 300);
          3:       s = SAMPLE_W'(int'($urandom_range(0, 16000)) - 8000);
          default: s = SAMPLE_W'($urandom);
        endcase
        eoc = ($urandom_range(0, 99) < eoc_pct);
        drive_sample(s, eoc);
      end
    end

    // all beats sent: wait out the last bursts, then the verdict
    drain_outputs();
    if (fail_count == 0) begin
      $display("windowed_adaptive_clipper test passed");
    end else begin
      $display("windowed_adaptive_clipper test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/wac_pkg.sv
src/wac_ram.sv
src/windowed_adaptive_clipper.sv
dv/windowed_adaptive_clipper_checker.sv
dv/windowed_adaptive_clipper_tb.sv
